// ----- rtl/smc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg
// Shared constants and types for the sysex message classifier.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam logic [7:0] SYX_START   = 8'hF0;
  localparam logic [7:0] SYX_END     = 8'hF7;
  localparam logic [7:0] UNIV_NRT    = 8'h7E;
  localparam logic [7:0] UNIV_RT     = 8'h7F;
  localparam logic [7:0] ID_GENERAL  = 8'h06;
  localparam logic [7:0] ID_REPLY    = 8'h02;

  localparam logic [1:0] KIND_MFR    = 2'd0;
  localparam logic [1:0] KIND_NRT    = 2'd1;
  localparam logic [1:0] KIND_RT     = 2'd2;

  localparam int POS_W      = 5;
  localparam int LEN_W      = POS_W + 1;
  localparam int HDR_TOP    = 15;  // highest header position ever read
  localparam int CK_START   = 5;
  localparam int CK_MIN_LEN = 8;
  localparam int ID_MIN_LEN = 15;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        complete;
    logic [15:0] manufacturer_id;
    logic [1:0]  universal_fields;
    logic [7:0]  device_id;
    logic [7:0]  sub_id_first;
    logic [7:0]  sub_id_second;
    logic        identity_ok;
    logic [15:0] family_code;
    logic [15:0] model_number;
    logic [31:0] software_revision;
    logic        checksum_ok;
  } result_t;

endpackage

// ----- rtl/smc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_in_if
// Byte channel into the classifier: one message byte and a last flag.
// ----------------------------------------------------------------------------
interface smc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

// ----- rtl/smc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_out_if
// Result channel out of the classifier: one item per finished message.
// ----------------------------------------------------------------------------
interface smc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        complete;
  logic [15:0] manufacturer_id;
  logic [1:0]  universal_fields;
  logic [7:0]  device_id;
  logic [7:0]  sub_id_first;
  logic [7:0]  sub_id_second;
  logic        identity_ok;
  logic [15:0] family_code;
  logic [15:0] model_number;
  logic [31:0] software_revision;
  logic        checksum_ok;

  modport source (output valid, kind, complete, manufacturer_id, universal_fields,
                  device_id, sub_id_first, sub_id_second, identity_ok, family_code,
                  model_number, software_revision, checksum_ok, input ready);
  modport sink   (input valid, kind, complete, manufacturer_id, universal_fields,
                  device_id, sub_id_first, sub_id_second, identity_ok, family_code,
                  model_number, software_revision, checksum_ok, output ready);
endinterface

// ----- rtl/smc_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_in_stage
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
module smc_in_stage (
  input  logic           clk,
  input  logic           rst,
  smc_in_if.sink         msg,
  input  logic           out_free,
  output logic           step,
  output smc_pkg::item_t item
);

  logic           held;
  smc_pkg::item_t item_q;

  // a last byte needs room in the result register, other bytes never wait
  assign step      = held && (!item_q.last || out_free);
  assign msg.ready = !held || step;
  assign item      = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      item_q.data_byte <= msg.data_byte;
      item_q.last      <= msg.last;
    end
  end

endmodule

// ----- rtl/smc_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_parser
// Message state (position, header bytes, running checksum, previous byte)
// and the classification of a message on its last byte.
// ----------------------------------------------------------------------------
module smc_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  smc_pkg::item_t   item,
  output smc_pkg::result_t result
);

  localparam int PW = smc_pkg::POS_W;
  localparam int LW = smc_pkg::LEN_W;

  logic [PW-1:0] byte_position, byte_position_next;
  logic [6:0]    checksum_sum, checksum_sum_next;
  logic [7:0]    previous_byte, previous_byte_next;
  logic [7:0]    header_store [1:smc_pkg::HDR_TOP];

  logic [7:0]    b;
  logic          framed;
  logic [PW-1:0] idx;
  logic [LW-1:0] len;
  logic [7:0]    prev_before;
  logic [7:0]    hv [1:smc_pkg::HDR_TOP];
  logic [1:0]    kind;
  logic          uni;
  logic          ext_id;
  logic [6:0]    sum_upd;
  logic [6:0]    ck_rest;
  logic [6:0]    ck_want;

  assign b           = item.data_byte;
  // a message that does not open with F0 gets one in front of it
  assign framed      = (byte_position == '0) && (b != smc_pkg::SYX_START);
  assign idx         = framed ? PW'(1) : byte_position;
  assign prev_before = framed ? smc_pkg::SYX_START : previous_byte;
  assign len         = {1'b0, idx} + LW'(1);

  // running sum with the current byte included from position CK_START on
  assign sum_upd     = (idx >= PW'(smc_pkg::CK_START)) ? checksum_sum + b[6:0] : checksum_sum;

  // header view with the current byte merged in
  always_comb begin
    for (int i = 1; i <= smc_pkg::HDR_TOP; i++) begin
      hv[i] = (idx == PW'(i)) ? b : header_store[i];
    end
  end

  always_comb begin
    checksum_sum_next  = sum_upd;
    byte_position_next = (idx == smc_pkg::POS_MAX) ? idx : idx + PW'(1);
    previous_byte_next = b;
    if (item.last) begin
      checksum_sum_next  = '0;
      byte_position_next = '0;
      previous_byte_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      checksum_sum  <= '0;
      previous_byte <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      checksum_sum  <= checksum_sum_next;
      previous_byte <= previous_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= smc_pkg::HDR_TOP; i++) begin
      if (step && idx == PW'(i)) begin
        header_store[i] <= b;
      end
    end
  end

  // classification, valid only on a last byte
  always_comb begin
    kind = smc_pkg::KIND_MFR;
    if (len >= LW'(2) && hv[1] == smc_pkg::UNIV_NRT) kind = smc_pkg::KIND_NRT;
    if (len >= LW'(2) && hv[1] == smc_pkg::UNIV_RT)  kind = smc_pkg::KIND_RT;
    uni    = kind != smc_pkg::KIND_MFR;
    ext_id = hv[5] == 8'h00;

    // sum over the checksummed span excludes the checksum and the end byte
    ck_rest = sum_upd - b[6:0] - prev_before[6:0];
    ck_want = 7'd0 - ck_rest;

    result                 = '0;
    result.kind            = kind;
    result.complete        = b == smc_pkg::SYX_END;

    if (len < LW'(2)) begin
      result.manufacturer_id = '0;
    end else if (!uni && hv[1] == 8'h00 && len >= LW'(4)) begin
      result.manufacturer_id = {hv[2], hv[3]};
    end else begin
      result.manufacturer_id = {8'h00, hv[1]};
    end

    if (uni) begin
      result.universal_fields = (len >= LW'(5)) ? 2'd3 : 2'(len - LW'(2));
      if (len >= LW'(3)) result.device_id     = hv[2];
      if (len >= LW'(4)) result.sub_id_first  = hv[3];
      if (len >= LW'(5)) result.sub_id_second = hv[4];
    end

    if (kind == smc_pkg::KIND_NRT && len >= LW'(smc_pkg::ID_MIN_LEN) &&
        hv[3] == smc_pkg::ID_GENERAL && hv[4] == smc_pkg::ID_REPLY &&
        (!ext_id || len >= LW'(smc_pkg::ID_MIN_LEN + 1))) begin
      result.identity_ok = 1'b1;
      if (ext_id) begin
        result.family_code       = {hv[9], hv[8]};
        result.model_number      = {hv[11], hv[10]};
        result.software_revision = {hv[15], hv[14], hv[13], hv[12]};
      end else begin
        result.family_code       = {hv[7], hv[6]};
        result.model_number      = {hv[9], hv[8]};
        result.software_revision = {hv[13], hv[12], hv[11], hv[10]};
      end
    end

    result.checksum_ok = (len >= LW'(smc_pkg::CK_MIN_LEN)) &&
                         (prev_before == {1'b0, ck_want});
  end

endmodule

// ----- rtl/smc_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_out_stage
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module smc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  smc_pkg::result_t result,
  output logic             out_free,
  smc_out_if.source        res
);

  logic             full;
  smc_pkg::result_t res_q;

  assign out_free  = !full || res.ready;
  assign res.valid = full;

  assign res.kind              = res_q.kind;
  assign res.complete          = res_q.complete;
  assign res.manufacturer_id   = res_q.manufacturer_id;
  assign res.universal_fields  = res_q.universal_fields;
  assign res.device_id         = res_q.device_id;
  assign res.sub_id_first      = res_q.sub_id_first;
  assign res.sub_id_second     = res_q.sub_id_second;
  assign res.identity_ok       = res_q.identity_ok;
  assign res.family_code       = res_q.family_code;
  assign res.model_number      = res_q.model_number;
  assign res.software_revision = res_q.software_revision;
  assign res.checksum_ok       = res_q.checksum_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (res.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= result;
    end
  end

endmodule

// ----- rtl/sysex_message_classifier_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_message_classifier_core
// Classifies system-exclusive messages delivered one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   msg carries one byte per item with a last flag on the final byte. A
//   message not opening with F0 is parsed as if F0 came first.
//   res carries one item per message, built from the whole message when its
//   last byte is taken: class, end marker, manufacturer ID, universal header
//   fields, identity reply fields and checksum check. Absent fields read zero.
//   Throughput: one byte per cycle, except while a last byte waits for the
//   result register; the parser updates its state and builds the result
//   combinationally between the input and result registers. A last byte is
//   held in the input register; its result is then registered for res.
//   Stall: bytes that are not last keep flowing while a result waits; a last
//   byte waits in the input register until the result register is free, and
//   msg.ready drops only then.
//   Reset (rst, synchronous) empties both registers and starts a new message;
//   header bytes need no clearing, only bytes of the current message are read.
// ----------------------------------------------------------------------------
module sysex_message_classifier_core (
  input  logic       clk,
  input  logic       rst,
  smc_in_if.sink     msg,
  smc_out_if.source  res
);

  logic             step;
  logic             out_free;
  smc_pkg::item_t   item;
  smc_pkg::result_t result;

  smc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .msg      (msg),
    .out_free (out_free),
    .step     (step),
    .item     (item)
  );

  smc_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  smc_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (step && item.last),
    .result   (result),
    .out_free (out_free),
    .res      (res)
  );

endmodule
